// ----- rtl/core/wdd_pkg.sv -----
// wdd_pkg: shared widths, controller/datapath handshake structs and the
// elaboration-time functions that build the Moebius divisor rows.
// No dependencies.
`default_nettype none

package wdd_pkg;

    localparam int DEGREE_W       = 7;
    localparam int WIDTH_W        = 16;
    localparam int COUNT_W        = 64;
    localparam int PROD_W         = COUNT_W + WIDTH_W;
    localparam int DEG_SPAN       = 1 << DEGREE_W;
    localparam int DIV_CNT_W      = $clog2(COUNT_W);
    localparam int MAX_DEGREE_DEF = 64;
    localparam logic [WIDTH_W-1:0] ALPHABET_RESET = 16'd2;

    // {negate mask, use mask}, bit e of each mask belongs to exponent e
    typedef logic [2*DEG_SPAN-1:0] t_row;

    typedef struct packed {
        logic start;
        logic mul;
        logic acc;
        logic div;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic k_bad;
        logic mul_ovf;
        logic last_e;
        logic div_last;
    } t_sts;

    // Moebius function by additive sieve: mu(n) = -sum of mu(d), d | n, d < n
    function automatic int mu_of(int n);
        int m [DEG_SPAN];
        int i;
        int j;
        for (i = 0; i < DEG_SPAN; i++) begin
            m[i] = 0;
        end
        m[1] = 1;
        for (i = 1; i <= n; i++) begin
            for (j = 2 * i; j <= n; j += i) begin
                m[j] -= m[i];
            end
        end
        return m[n];
    endfunction

    // Divisor row for degree k: for every d | k with mu(d) != 0, flag e = k/d
    function automatic t_row row_of(int k, int max_deg);
        t_row r;
        int   d;
        int   p;
        int   e;
        int   mu;
        r = '0;
        if (k >= 1 && k <= max_deg) begin
            for (d = 1; d <= k; d++) begin
                e = 0;
                for (p = d; p <= k; p += d) begin
                    e++;
                    if (p == k) begin
                        mu = mu_of(d);
                        if (mu != 0) begin
                            r[e] = 1'b1;
                        end
                        if (mu < 0) begin
                            r[DEG_SPAN + e] = 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wdd_ctrl.sv -----
// wdd_ctrl: sequencer for one item (power/accumulate loop, bit-serial
// division, result hand-off). Depends on wdd_pkg.
`default_nettype none

module wdd_ctrl import wdd_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_out_free,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.k_bad) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    // stop at the first power that leaves 64 bits
                    n_state   = i_sts.mul_ovf ? S_FIN : S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last_e ? S_DIV : S_MUL;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/wdd_dpath.sv -----
// wdd_dpath: divisor-row table, power multiplier, signed accumulator and
// restoring divider that reuses the accumulator as quotient. Depends on wdd_pkg.
`default_nettype none

module wdd_dpath import wdd_pkg::*; #(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire                 i_clk,
    input  t_cmd                i_cmd,
    input  wire  [DEGREE_W-1:0] i_degree,
    input  wire  [WIDTH_W-1:0]  i_alphabet_width,
    output t_sts                o_sts,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_overflow
);

    localparam int CMP_W = DEGREE_W + 2;

    t_row w_rows [DEG_SPAN];

    for (genvar g = 0; g < DEG_SPAN; g++) begin : g_rows
        assign w_rows[g] = row_of(g, MAX_DEGREE);
    end

    logic [DEGREE_W-1:0]  r_k;
    logic [DEGREE_W-1:0]  r_e;
    logic [DEG_SPAN-1:0]  r_use;
    logic [DEG_SPAN-1:0]  r_neg;
    logic [COUNT_W-1:0]   r_pow;
    logic [COUNT_W-1:0]   r_acc;
    logic [DEGREE_W-1:0]  r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_ovf;
    logic                 r_bad;

    logic [PROD_W-1:0]    w_prod;
    logic [DEGREE_W:0]    w_rem_sh;
    logic                 w_ge;

    assign w_prod   = PROD_W'(r_pow) * PROD_W'(i_alphabet_width);
    assign w_rem_sh = {r_rem, r_acc[COUNT_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_k});

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_k   <= i_degree;
            r_e   <= '0;
            r_use <= w_rows[i_degree][DEG_SPAN-1:0];
            r_neg <= w_rows[i_degree][2*DEG_SPAN-1:DEG_SPAN];
            r_pow <= COUNT_W'(1);
            r_acc <= '0;
            r_rem <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_bad <= (i_degree == '0) ||
                     (CMP_W'(i_degree) > CMP_W'(MAX_DEGREE));
        end
        if (i_cmd.mul) begin
            r_pow <= w_prod[COUNT_W-1:0];
            r_e   <= r_e + DEGREE_W'(1);
            r_ovf <= o_sts.mul_ovf;
        end
        // sum wraps mod 2^64; the exact total always lies in 0 .. w^k
        if (i_cmd.acc && r_use[r_e]) begin
            r_acc <= r_neg[r_e] ? (r_acc - r_pow) : (r_acc + r_pow);
        end
        if (i_cmd.div) begin
            r_rem <= w_ge ? DEGREE_W'(w_rem_sh - {1'b0, r_k})
                          : w_rem_sh[DEGREE_W-1:0];
            r_acc <= {r_acc[COUNT_W-2:0], w_ge};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_sts.k_bad    = r_bad;
    assign o_sts.mul_ovf  = |w_prod[PROD_W-1:COUNT_W];
    assign o_sts.last_e   = (r_e == r_k);
    assign o_sts.div_last = &r_cnt;

    assign o_count    = r_bad ? '0 : (r_ovf ? '1 : r_acc);
    assign o_overflow = ~r_bad & r_ovf;

endmodule

`default_nettype wire

// ----- rtl/core/witt_degree_dimension.sv -----
// Witt dimension unit, top level: alphabet register, output register and
// the controller/datapath pair. Depends on wdd_pkg, wdd_ctrl, wdd_dpath.
//
//  channel   direction  handshake              payload
//  s (k)     in         i_s_tvalid/o_s_tready  tdata[6:0] degree
//  m (dim)   out        o_m_tvalid/i_m_tready  tdata[63:0] count, tuser overflow
//  cfg       in         i_cfg_wr_en            i_cfg_wr_data alphabet_width
//
// An item of degree k runs from acceptance to the result register as one
// multiply and one accumulate step per exponent, then 64 steps of the
// one-bit restoring divider. Out-of-range degrees skip from the multiply
// state to the finish state, an overflowing power stops the loop at its
// first overflowing multiply. Reset is synchronous, active low, and sets
// alphabet_width to 2. A stalled result waits in the output register
// while the next item is accepted and worked on.
`default_nettype none

module witt_degree_dimension import wdd_pkg::*; #(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  wire  [7:0]         i_s_tdata,      // [6:0] degree, [7] zero
    output logic               o_m_tvalid,
    input  wire                i_m_tready,
    output logic [COUNT_W-1:0] o_m_tdata,      // [63:0] count
    output logic               o_m_tuser,      // [0] overflow
    input  wire                i_cfg_wr_en,
    input  wire  [WIDTH_W-1:0] i_cfg_wr_data   // alphabet_width
);

    logic [WIDTH_W-1:0] r_alphabet_width;
    logic               r_m_valid;
    logic [COUNT_W-1:0] r_m_data;
    logic               r_m_user;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_in_ready;
    logic               w_out_free;
    logic [COUNT_W-1:0] w_count;
    logic               w_overflow;

    assign w_out_free = ~r_m_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_width <= ALPHABET_RESET;
        end else if (i_cfg_wr_en) begin
            r_alphabet_width <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_m_data <= w_count;
            r_m_user <= w_overflow;
        end
    end

    wdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    wdd_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_degree         (i_s_tdata[DEGREE_W-1:0]),
        .i_alphabet_width (r_alphabet_width),
        .o_sts            (w_sts),
        .o_count          (w_count),
        .o_overflow       (w_overflow)
    );

    assign o_s_tready = w_in_ready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // a saturated result always carries an all-ones count
    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> &o_m_tdata)
        else $error("overflow flagged without saturated count");

    // one item at a time: the input closes right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // a result never overwrites one that has not been taken
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_m_valid || i_m_tready))
        else $error("pending result overwritten");

    // a result is loaded only while no new item is being accepted
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_in_ready)
        else $error("result loaded while input open");

endmodule

`default_nettype wire
